// ===== hdl/bnms_pkg.sv =====
// Package: shared constants, box geometry, controller states, command and status structs.
`timescale 1ns / 1ps
package bnms_pkg;

  localparam int MAX_BOXES_DEF = 64;
  localparam logic [15:0] IOU_RESET = 16'd26214;

  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [14:0]        w;
    logic [14:0]        h;
  } box_t;

  localparam int BOX_W = $bits(box_t);

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_RK_I,
    ST_RK_IW,
    ST_RK_J,
    ST_RK_JC,
    ST_RK_WR,
    ST_SP_I,
    ST_SP_IA,
    ST_SP_IS,
    ST_SP_IL,
    ST_SP_J,
    ST_SP_JA,
    ST_SP_JC,
    ST_SP_JL,
    ST_SP_M1,
    ST_SP_M2,
    ST_SP_M3,
    ST_SP_M4,
    ST_SP_DEC,
    ST_SP_NI,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_W
  } state_t;

  typedef enum logic [1:0] {
    SR_I,
    SR_J,
    SR_A
  } ssel_t;

  typedef struct packed {
    logic  in_open;
    logic  clr_set;
    logic  i_clr;
    logic  i_inc;
    logic  j_clr;
    logic  j_from_i;
    logic  j_inc;
    logic  cnt_clr;
    logic  cnt_upd;
    logic  si_ld;
    logic  rank_wr;
    logic  rank_sel_j;
    logic  a_ld;
    logic  b_ld;
    logic  coord_sel_b;
    logic  ca_ld;
    logic  cb_ld;
    logic  sup_wr;
    logic  out_ld;
    ssel_t ssel;
  } cmd_t;

  typedef struct packed {
    logic item_fire;
    logic item_last;
    logic i_last;
    logic j_last;
    logic a_zero;
    logic out_busy;
  } stat_t;

endpackage

// ===== hdl/bnms_if.sv =====
// Interfaces: box input channel, result channel and threshold write channel.
`timescale 1ns / 1ps
interface bnms_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] center_x;
  logic signed [15:0] center_y;
  logic [14:0]        box_width;
  logic [14:0]        box_height;
  logic [15:0]        score;
  logic               last_box;
  modport source (output valid, center_x, center_y, box_width, box_height, score, last_box,
                  input ready);
  modport sink (input valid, center_x, center_y, box_width, box_height, score, last_box,
                output ready);
endinterface

interface bnms_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  box_index;
  logic        kept;
  logic [15:0] final_score;
  logic        overflow;
  logic        last_result;
  modport source (output valid, box_index, kept, final_score, overflow, last_result,
                  input ready);
  modport sink (input valid, box_index, kept, final_score, overflow, last_result,
                output ready);
endinterface

interface bnms_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hdl/bnms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bnms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/bnms_ctrl.sv =====
// Controller: sequences load, ranking, pairwise suppression and result output.
`timescale 1ns / 1ps
module bnms_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  bnms_pkg::stat_t  st,
  output bnms_pkg::cmd_t   cmd
);

  bnms_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bnms_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bnms_pkg::ST_LOAD:   if (st.item_fire && st.item_last) state_nxt = bnms_pkg::ST_RK_I;
      bnms_pkg::ST_RK_I:   state_nxt = bnms_pkg::ST_RK_IW;
      bnms_pkg::ST_RK_IW:  state_nxt = bnms_pkg::ST_RK_J;
      bnms_pkg::ST_RK_J:   state_nxt = bnms_pkg::ST_RK_JC;
      bnms_pkg::ST_RK_JC:  state_nxt = st.j_last ? bnms_pkg::ST_RK_WR : bnms_pkg::ST_RK_J;
      bnms_pkg::ST_RK_WR:  state_nxt = st.i_last ? bnms_pkg::ST_SP_I : bnms_pkg::ST_RK_I;
      bnms_pkg::ST_SP_I:   state_nxt = bnms_pkg::ST_SP_IA;
      bnms_pkg::ST_SP_IA:  state_nxt = bnms_pkg::ST_SP_IS;
      bnms_pkg::ST_SP_IS:  state_nxt = bnms_pkg::ST_SP_IL;
      bnms_pkg::ST_SP_IL: begin
        state_nxt = (st.a_zero || st.i_last) ? bnms_pkg::ST_SP_NI : bnms_pkg::ST_SP_J;
      end
      bnms_pkg::ST_SP_J:   state_nxt = bnms_pkg::ST_SP_JA;
      bnms_pkg::ST_SP_JA:  state_nxt = bnms_pkg::ST_SP_JC;
      bnms_pkg::ST_SP_JC:  state_nxt = bnms_pkg::ST_SP_JL;
      bnms_pkg::ST_SP_JL:  state_nxt = bnms_pkg::ST_SP_M1;
      bnms_pkg::ST_SP_M1:  state_nxt = bnms_pkg::ST_SP_M2;
      bnms_pkg::ST_SP_M2:  state_nxt = bnms_pkg::ST_SP_M3;
      bnms_pkg::ST_SP_M3:  state_nxt = bnms_pkg::ST_SP_M4;
      bnms_pkg::ST_SP_M4:  state_nxt = bnms_pkg::ST_SP_DEC;
      bnms_pkg::ST_SP_DEC: state_nxt = st.j_last ? bnms_pkg::ST_SP_NI : bnms_pkg::ST_SP_J;
      bnms_pkg::ST_SP_NI:  state_nxt = st.i_last ? bnms_pkg::ST_OUT_RD : bnms_pkg::ST_SP_I;
      bnms_pkg::ST_OUT_RD: state_nxt = bnms_pkg::ST_OUT_LD;
      bnms_pkg::ST_OUT_LD: state_nxt = bnms_pkg::ST_OUT_W;
      bnms_pkg::ST_OUT_W: begin
        if (!st.out_busy) begin
          state_nxt = st.i_last ? bnms_pkg::ST_LOAD : bnms_pkg::ST_OUT_RD;
        end
      end
      default: state_nxt = bnms_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.ssel = bnms_pkg::SR_I;
    case (state_r)
      bnms_pkg::ST_LOAD: begin
        cmd.in_open = 1'b1;
        cmd.i_clr   = 1'b1;
      end
      bnms_pkg::ST_RK_I:  cmd.ssel = bnms_pkg::SR_I;
      bnms_pkg::ST_RK_IW: begin
        cmd.si_ld   = 1'b1;
        cmd.j_clr   = 1'b1;
        cmd.cnt_clr = 1'b1;
      end
      bnms_pkg::ST_RK_J:  cmd.ssel = bnms_pkg::SR_J;
      bnms_pkg::ST_RK_JC: begin
        cmd.cnt_upd = 1'b1;
        cmd.j_inc   = 1'b1;
      end
      bnms_pkg::ST_RK_WR: begin
        cmd.rank_wr = 1'b1;
        cmd.i_clr   = st.i_last;
        cmd.i_inc   = !st.i_last;
      end
      bnms_pkg::ST_SP_I:  cmd.rank_sel_j = 1'b0;
      bnms_pkg::ST_SP_IA: cmd.a_ld = 1'b1;
      bnms_pkg::ST_SP_IS: begin
        cmd.ssel        = bnms_pkg::SR_A;
        cmd.coord_sel_b = 1'b0;
      end
      bnms_pkg::ST_SP_IL: begin
        cmd.ca_ld    = 1'b1;
        cmd.j_from_i = 1'b1;
      end
      bnms_pkg::ST_SP_J:   cmd.rank_sel_j = 1'b1;
      bnms_pkg::ST_SP_JA:  cmd.b_ld = 1'b1;
      bnms_pkg::ST_SP_JC:  cmd.coord_sel_b = 1'b1;
      bnms_pkg::ST_SP_JL:  cmd.cb_ld = 1'b1;
      bnms_pkg::ST_SP_DEC: begin
        cmd.sup_wr = 1'b1;
        cmd.j_inc  = 1'b1;
      end
      bnms_pkg::ST_SP_NI: begin
        cmd.i_clr = st.i_last;
        cmd.i_inc = !st.i_last;
      end
      bnms_pkg::ST_OUT_RD: cmd.ssel = bnms_pkg::SR_I;
      bnms_pkg::ST_OUT_LD: cmd.out_ld = 1'b1;
      bnms_pkg::ST_OUT_W: begin
        if (!st.out_busy) begin
          cmd.clr_set = st.i_last;
          cmd.i_inc   = !st.i_last;
        end
      end
      default: cmd.ssel = bnms_pkg::SR_I;
    endcase
  end

endmodule

// ===== hdl/bnms_dp.sv =====
// Datapath: box stores, rank counter, staged IoU test, threshold register, result register.
`timescale 1ns / 1ps
module bnms_dp #(
  parameter int MaxBoxes = bnms_pkg::MAX_BOXES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  bnms_in_if.sink          in_ch,
  bnms_out_if.source       out_ch,
  bnms_cfg_if.sink         cfg_ch,
  input  bnms_pkg::cmd_t   cmd,
  output bnms_pkg::stat_t  st
);

  localparam int IW = $clog2(MaxBoxes);
  localparam int CW = $clog2(MaxBoxes + 1);

  logic [CW-1:0]  count_r;
  logic           ovf_r;
  logic [IW-1:0]  i_r, j_r, cnt_r, a_r, b_r;
  logic [15:0]    si_r, thr_r;
  bnms_pkg::box_t ca_r, cb_r, in_box, coord_q;

  logic           fire, room, over, beat;
  logic           score_we;
  logic [IW-1:0]  score_waddr, score_raddr, rank_raddr, coord_raddr;
  logic [15:0]    score_wdata, score_q;
  logic [IW-1:0]  rank_q;

  // IoU pipeline
  logic signed [18:0] ax2, bx2, ay2, by2, aw, ah, bw, bh;
  logic signed [18:0] lo_x, hi_x, lo_y, hi_y, ox, oy;
  logic signed [18:0] ox_r, oy_r;
  logic               neg1_r, neg2_r, kill3_r, kill4_r;
  logic [29:0]        aa_r, ab_r;
  logic [30:0]        asum_r;
  logic [35:0]        inter2_r, inter3_r, inter4_r, uni4;
  logic [32:0]        uni_r;
  logic [48:0]        prod_r;

  logic        out_valid_r, kept_r, outovf_r, outlast_r;
  logic [5:0]  box_index_r;
  logic [15:0] final_score_r;

  assign fire  = in_ch.valid && in_ch.ready;
  assign room  = (count_r != CW'(MaxBoxes));
  assign in_ch.ready  = cmd.in_open;
  assign cfg_ch.ready = 1'b1;

  assign in_box.cx = in_ch.center_x;
  assign in_box.cy = in_ch.center_y;
  assign in_box.w  = in_ch.box_width;
  assign in_box.h  = in_ch.box_height;

  assign st.item_fire = fire;
  assign st.item_last = in_ch.last_box;
  assign st.i_last    = ((CW'(i_r) + CW'(1)) == count_r);
  assign st.j_last    = ((CW'(j_r) + CW'(1)) == count_r);
  assign st.a_zero    = (score_q == 16'd0);
  assign st.out_busy  = out_valid_r;

  always_comb begin
    case (cmd.ssel)
      bnms_pkg::SR_I: score_raddr = i_r;
      bnms_pkg::SR_J: score_raddr = j_r;
      bnms_pkg::SR_A: score_raddr = a_r;
      default:        score_raddr = i_r;
    endcase
  end

  assign rank_raddr  = cmd.rank_sel_j ? j_r : i_r;
  assign coord_raddr = cmd.coord_sel_b ? b_r : a_r;

  always_comb begin
    score_we    = 1'b0;
    score_waddr = count_r[IW-1:0];
    score_wdata = in_ch.score;
    if (fire && room) begin
      score_we = 1'b1;
    end else if (cmd.sup_wr && over) begin
      score_we    = 1'b1;
      score_waddr = b_r;
      score_wdata = 16'd0;
    end
  end

  bnms_ram #(.WIDTH(16), .DEPTH(MaxBoxes)) u_score_ram (
    .clk   (clk),
    .we    (score_we),
    .waddr (score_waddr),
    .wdata (score_wdata),
    .raddr (score_raddr),
    .rdata (score_q)
  );

  bnms_ram #(.WIDTH(bnms_pkg::BOX_W), .DEPTH(MaxBoxes)) u_coord_ram (
    .clk   (clk),
    .we    (fire && room),
    .waddr (count_r[IW-1:0]),
    .wdata (in_box),
    .raddr (coord_raddr),
    .rdata (coord_q)
  );

  bnms_ram #(.WIDTH(IW), .DEPTH(MaxBoxes)) u_rank_ram (
    .clk   (clk),
    .we    (cmd.rank_wr),
    .waddr (cnt_r),
    .wdata (i_r),
    .raddr (rank_raddr),
    .rdata (rank_q)
  );

  // higher score first, ties to the lower load index
  assign beat = (score_q > si_r) || ((score_q == si_r) && (j_r < i_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      thr_r   <= bnms_pkg::IOU_RESET;
    end else begin
      if (cfg_ch.valid) begin
        thr_r <= cfg_ch.data;
      end
      if (cmd.clr_set) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end else if (fire) begin
        if (room) begin
          count_r <= count_r + CW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.i_clr) begin
      i_r <= '0;
    end else if (cmd.i_inc) begin
      i_r <= i_r + IW'(1);
    end
    if (cmd.j_clr) begin
      j_r <= '0;
    end else if (cmd.j_from_i) begin
      j_r <= i_r + IW'(1);
    end else if (cmd.j_inc) begin
      j_r <= j_r + IW'(1);
    end
    if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_upd && beat) begin
      cnt_r <= cnt_r + IW'(1);
    end
    if (cmd.si_ld) si_r <= score_q;
    if (cmd.a_ld)  a_r  <= rank_q;
    if (cmd.b_ld)  b_r  <= rank_q;
    if (cmd.ca_ld) ca_r <= coord_q;
    if (cmd.cb_ld) cb_r <= coord_q;
  end

  // overlap in doubled units
  assign ax2 = {{2{ca_r.cx[15]}}, ca_r.cx, 1'b0};
  assign bx2 = {{2{cb_r.cx[15]}}, cb_r.cx, 1'b0};
  assign ay2 = {{2{ca_r.cy[15]}}, ca_r.cy, 1'b0};
  assign by2 = {{2{cb_r.cy[15]}}, cb_r.cy, 1'b0};
  assign aw  = {4'b0, ca_r.w};
  assign ah  = {4'b0, ca_r.h};
  assign bw  = {4'b0, cb_r.w};
  assign bh  = {4'b0, cb_r.h};

  assign lo_x = ((ax2 - aw) > (bx2 - bw)) ? (ax2 - aw) : (bx2 - bw);
  assign hi_x = ((ax2 + aw) < (bx2 + bw)) ? (ax2 + aw) : (bx2 + bw);
  assign lo_y = ((ay2 - ah) > (by2 - bh)) ? (ay2 - ah) : (by2 - bh);
  assign hi_y = ((ay2 + ah) < (by2 + bh)) ? (ay2 + ah) : (by2 + bh);
  assign ox   = hi_x - lo_x;
  assign oy   = hi_y - lo_y;

  assign uni4 = 36'({asum_r, 2'b00});
  assign over = !kill4_r && ({inter4_r, 16'd0} > 52'(prod_r));

  always_ff @(posedge clk) begin
    ox_r     <= ox;
    oy_r     <= oy;
    neg1_r   <= ox[18] || oy[18];
    aa_r     <= 30'(ca_r.w) * 30'(ca_r.h);
    ab_r     <= 30'(cb_r.w) * 30'(cb_r.h);
    inter2_r <= 36'(ox_r[17:0]) * 36'(oy_r[17:0]);
    neg2_r   <= neg1_r;
    asum_r   <= 31'(aa_r) + 31'(ab_r);
    kill3_r  <= neg2_r || (uni4 <= inter2_r);
    uni_r    <= 33'(uni4 - inter2_r);
    inter3_r <= inter2_r;
    prod_r   <= 49'(thr_r) * 49'(uni_r);
    inter4_r <= inter3_r;
    kill4_r  <= kill3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      box_index_r   <= 6'(i_r);
      kept_r        <= (score_q != 16'd0);
      final_score_r <= score_q;
      outovf_r      <= ovf_r;
      outlast_r     <= st.i_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.box_index   = box_index_r;
  assign out_ch.kept        = kept_r;
  assign out_ch.final_score = final_score_r;
  assign out_ch.overflow    = outovf_r;
  assign out_ch.last_result = outlast_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MaxBoxes))
    else $error("box count above capacity");

  a_rank_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rank_wr |-> (CW'(cnt_r) < count_r))
    else $error("rank slot outside stored set");

  a_ovf_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !room && !cmd.clr_set) |=> ovf_r)
    else $error("dropped box not flagged");

  a_no_load_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.in_open |-> !out_valid_r)
    else $error("input open while result pending");

endmodule

// ===== hdl/box_non_maximum_suppression.sv =====
// Top level: greedy score-ordered box suppression with IoU threshold.
//
//  channel  dir  handshake          payload
//  in_ch    in   valid/ready        center_x center_y box_width box_height score last_box
//  out_ch   out  valid/ready        box_index kept final_score overflow last_result
//  cfg_ch   in   valid/ready(high)  data = iou_threshold
//
// Loading accepts one item per cycle; extra items beyond MAX_BOXES are dropped and flagged.
// After the last item, ranking runs over all pairs (one shared score RAM read port), then
// suppression tests pairs in rank order (serial IoU unit, four stages), then results go
// out one at a time, each waiting until out_ch accepts it.
// Reset restores iou_threshold to 0.40 and empties the set; out_ch stalls hold the result.
`timescale 1ns / 1ps
module box_non_maximum_suppression #(
  parameter int MAX_BOXES = bnms_pkg::MAX_BOXES_DEF
) (
  input logic         clk,
  input logic         rst_n,
  bnms_in_if.sink     in_ch,
  bnms_out_if.source  out_ch,
  bnms_cfg_if.sink    cfg_ch
);

  bnms_pkg::cmd_t  cmd;
  bnms_pkg::stat_t st;

  bnms_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  bnms_dp #(.MaxBoxes(MAX_BOXES)) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .st     (st)
  );

endmodule

// ===== tb/box_non_maximum_suppression_test.sv =====
// Testbench: random and directed box sets through NMS, checked against a local predictor.
`timescale 1ns / 1ps
module box_non_maximum_suppression_test;

  localparam int NBOX = bnms_pkg::MAX_BOXES_DEF;
  localparam int WATCHDOG = 200000;

  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [14:0]        w;
    logic [14:0]        h;
    logic [15:0]        score;
    logic               last;
  } box_item_t;

  typedef struct packed {
    logic [5:0]  idx;
    logic        kept;
    logic [15:0] score;
    logic        ovf;
    logic        last;
  } verdict_t;

  logic clk;
  logic rst_n;
  bnms_in_if  in_ch ();
  bnms_out_if out_ch ();
  bnms_cfg_if cfg_ch ();

  box_non_maximum_suppression i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  box_item_t pending_boxes[$];
  verdict_t  expected_verdicts[$];
  bnms_pkg::box_t set_geom[NBOX];
  logic [15:0] set_score[NBOX];
  int        set_count;
  logic      set_ovf;
  logic [15:0] threshold;
  bit        quiet;
  bit        failed;
  int        idle_in;
  int        stall_out;
  int        quiet_cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic bit overlaps_over(bnms_pkg::box_t a, bnms_pkg::box_t b,
                                       logic [15:0] thr);
    longint ax, ay, aw, ah, bx, by, bw, bh;
    longint lox, hix, loy, hiy, ox, oy, inter, uni;
    ax = 2 * longint'(a.cx);
    ay = 2 * longint'(a.cy);
    bx = 2 * longint'(b.cx);
    by = 2 * longint'(b.cy);
    aw = longint'(a.w);
    ah = longint'(a.h);
    bw = longint'(b.w);
    bh = longint'(b.h);
    lox = (ax - aw) > (bx - bw) ? (ax - aw) : (bx - bw);
    hix = (ax + aw) < (bx + bw) ? (ax + aw) : (bx + bw);
    loy = (ay - ah) > (by - bh) ? (ay - ah) : (by - bh);
    hiy = (ay + ah) < (by + bh) ? (ay + ah) : (by + bh);
    ox = hix - lox;
    oy = hiy - loy;
    if (ox < 0 || oy < 0) return 0;
    inter = ox * oy;
    uni = 4 * (aw * ah) + 4 * (bw * bh);
    if (uni <= inter) return 0;
    uni = uni - inter;
    return (inter * 65536) > (longint'(thr) * uni);
  endfunction

  task automatic close_set();
    int rank[NBOX];
    int i, j, s, a;
    verdict_t v;
    for (i = 0; i < set_count; i++) begin
      s = set_score[i];
      j = i;
      while (j > 0 && set_score[rank[j - 1]] < s) begin
        rank[j] = rank[j - 1];
        j--;
      end
      rank[j] = i;
    end
    for (i = 0; i < set_count; i++) begin
      a = rank[i];
      if (set_score[a] != 0)
        for (j = i + 1; j < set_count; j++)
          if (overlaps_over(set_geom[a], set_geom[rank[j]], threshold))
            set_score[rank[j]] = 0;
    end
    for (i = 0; i < set_count; i++) begin
      v = {6'(i), set_score[i] != 0, set_score[i], set_ovf, i == set_count - 1};
      expected_verdicts = {expected_verdicts, v};
    end
    set_count = 0;
    set_ovf = 0;
  endtask

  task automatic predict_box(box_item_t b);
    if (set_count < NBOX) begin
      set_geom[set_count] = '{cx: b.cx, cy: b.cy, w: b.w, h: b.h};
      set_score[set_count] = b.score;
      set_count++;
    end else begin
      set_ovf = 1;
    end
    if (b.last) close_set();
  endtask

  function automatic box_item_t random_box(int spread, bit last);
    box_item_t b;
    b.cx = 16'($urandom_range(0, spread) - spread / 2);
    b.cy = 16'($urandom_range(0, spread) - spread / 2);
    b.w = 15'($urandom_range(0, 32767));
    b.h = 15'($urandom_range(0, 32767));
    if ($urandom_range(0, 3) == 0) b.w = 15'($urandom_range(0, 300));
    b.score = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 5) == 0) b.score = 16'($urandom_range(0, 3));
    b.last = last;
    return b;
  endfunction

  task automatic add_box(box_item_t b);
    pending_boxes = {pending_boxes, b};
  endtask

  task automatic add_set(int n, int spread);
    for (int k = 0; k < n; k++)
      add_box(random_box(spread, k == n - 1));
  endtask

  task automatic drain();
    while (pending_boxes.size() != 0 || expected_verdicts.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_threshold(logic [15:0] v);
    cfg_ch.valid <= 1;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 0;
    threshold = v;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 0;
      idle_in <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_box(pending_boxes.pop_front());
      end
      if (in_ch.valid && !in_ch.ready) begin
      end else if (idle_in > 0) begin
        in_ch.valid <= 0;
        idle_in <= idle_in - 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        in_ch.valid <= 0;
        idle_in <= $urandom_range(0, 6);
      end else if (pending_boxes.size() != 0) begin
        in_ch.valid <= 1;
        {in_ch.center_x, in_ch.center_y, in_ch.box_width, in_ch.box_height,
         in_ch.score, in_ch.last_box} <= pending_boxes[0];
      end else begin
        in_ch.valid <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    verdict_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 0;
      stall_out <= 0;
      quiet_cycles <= 0;
    end else begin
      if (stall_out > 0) begin
        out_ch.ready <= 0;
        stall_out <= stall_out - 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 0;
        stall_out <= $urandom_range(0, 6);
      end else begin
        out_ch.ready <= 1;
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.box_index, out_ch.kept, out_ch.final_score, out_ch.overflow,
               out_ch.last_result};
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          failed = 1;
        end else begin
          want = expected_verdicts.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            failed = 1;
          end
        end
      end
      if (quiet_cycles > WATCHDOG) begin
        $display("box_non_maximum_suppression_test: FAIL");
        $finish;
      end
    end
  end

  initial begin
    failed = 0;
    quiet = 0;
    set_count = 0;
    set_ovf = 0;
    threshold = bnms_pkg::IOU_RESET;
    rst_n = 0;
    in_ch.valid = 0;
    {in_ch.center_x, in_ch.center_y, in_ch.box_width, in_ch.box_height,
     in_ch.score, in_ch.last_box} = '0;
    cfg_ch.valid = 0;
    cfg_ch.data = 0;
    out_ch.ready = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset threshold, identical boxes, extremes, zero scores, ties
    add_box('{16'sh7fff, 16'sh8000, 15'h7fff, 15'h7fff, 16'hffff, 0});
    add_box('{16'sh7fff, 16'sh8000, 15'h7fff, 15'h7fff, 16'hffff, 0});
    add_box('{16'sh8000, 16'sh7fff, 15'h7fff, 15'h0, 16'h1234, 0});
    add_box('{16'sh0, 16'sh0, 15'h0, 15'h0, 16'h0, 0});
    add_box('{16'sh0, 16'sh0, 15'd1000, 15'd1000, 16'h0, 0});
    add_box('{16'sh0, 16'sh0, 15'd1000, 15'd900, 16'd5, 0});
    add_box('{16'sh0, 16'sh0, 15'd1000, 15'd1000, 16'd5, 0});
    add_box('{16'sd500, 16'sh0, 15'd1000, 15'd1000, 16'd7, 0});
    add_box('{16'sd1000, 16'sh0, 15'd1000, 15'd1000, 16'd9, 1});
    add_box('{16'sh0, 16'sh0, 15'd10, 15'd10, 16'd1, 1});
    drain();
    write_threshold(16'd0);
    add_box('{16'sh0, 16'sh0, 15'd100, 15'd100, 16'd50, 0});
    add_box('{16'sd99, 16'sh0, 15'd100, 15'd100, 16'd40, 0});
    add_box('{16'sd100, 16'sh0, 15'd100, 15'd100, 16'd30, 1});
    drain();
    // overflow: full set plus three extra boxes, all dropped including the last one
    add_set(NBOX + 3, 2000);
    drain();
    write_threshold(16'hffff);
    add_set(NBOX, 400);
    add_set(5, 400);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_threshold(ph == 0 ? 16'd1 : 16'($urandom_range(0, 65535)));
      if (ph == 3) quiet = 1;
      for (int s = 0; s < 2; s++)
        add_set($urandom_range(1, 4), $urandom_range(0, 1) ? 600 : 65535);
      drain();
    end

    if (failed)
      $display("box_non_maximum_suppression_test: FAIL");
    else
      $display("box_non_maximum_suppression_test: PASS");
    $finish;
  end
endmodule
